### rtl/core/t3d_pkg.sv
// ----------------------------------------------------------------------------
// t3d_pkg: shared types and constants of the 3D turtle path interpreter
// Opcodes, angle constants, CORDIC arctangent table and channel payloads.
// ----------------------------------------------------------------------------
package t3d_pkg;

   typedef enum logic [2:0] {
      OP_FORWARD   = 3'd0,
      OP_YAW_UP    = 3'd1,
      OP_YAW_DN    = 3'd2,
      OP_PITCH_UP  = 3'd3,
      OP_PITCH_DN  = 3'd4,
      OP_PUSH      = 3'd5,
      OP_POP       = 3'd6,
      OP_RESTART   = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      REG_DEFAULT_STEP  = 3'd0,
      REG_DEFAULT_YAW   = 3'd1,
      REG_DEFAULT_PITCH = 3'd2,
      REG_START_X       = 3'd3,
      REG_START_Y       = 3'd4,
      REG_START_Z       = 3'd5,
      REG_START_PITCH   = 3'd6,
      REG_START_YAW     = 3'd7
   } reg_index_type;

   localparam int unsigned CSR_INDEX_W = 4;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [16:0] FULL_TURN    = 17'd46080;
   localparam logic [16:0] HALF_TURN    = 17'd23040;
   localparam logic [16:0] QUARTER_TURN = 17'd11520;
   localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
   localparam int unsigned ATAN_COUNT = 24;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [15:0] amount;
   } req_type;

   typedef struct packed {
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] from_z;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic signed [31:0] to_z;
      logic               overflow_seen;
   } rsp_type;

   function automatic logic [29:0] atan_deg23(input logic [4:0] i);
      logic [29:0] r;
      unique case (i)
         5'd0:  r = 30'd377487360;
         5'd1:  r = 30'd222843801;
         5'd2:  r = 30'd117744544;
         5'd3:  r = 30'd59768969;
         5'd4:  r = 30'd30000467;
         5'd5:  r = 30'd15014858;
         5'd6:  r = 30'd7509261;
         5'd7:  r = 30'd3754860;
         5'd8:  r = 30'd1877459;
         5'd9:  r = 30'd938733;
         5'd10: r = 30'd469367;
         5'd11: r = 30'd234683;
         5'd12: r = 30'd117342;
         5'd13: r = 30'd58671;
         5'd14: r = 30'd29336;
         5'd15: r = 30'd14668;
         5'd16: r = 30'd7334;
         5'd17: r = 30'd3667;
         5'd18: r = 30'd1834;
         5'd19: r = 30'd917;
         5'd20: r = 30'd458;
         5'd21: r = 30'd229;
         5'd22: r = 30'd115;
         5'd23: r = 30'd57;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/t3d_req_if.sv
// ----------------------------------------------------------------------------
// t3d_req_if / t3d_rsp_if: command and segment channels
// Valid/ready channels carrying one command item or one segment item.
// ----------------------------------------------------------------------------
interface t3d_req_if;
   logic               valid;
   logic               ready;
   t3d_pkg::req_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface t3d_rsp_if;
   logic               valid;
   logic               ready;
   t3d_pkg::rsp_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/turtle_3d_path_interpreter.sv
// ----------------------------------------------------------------------------
// turtle_3d_path_interpreter: 3D turtle command interpreter
// Executes tokenized turtle commands and emits one line segment per forward.
// ----------------------------------------------------------------------------
// One command item is taken at a time; req.ready is low until it is done.
// Turns and push return to idle straight from the execute step; pop also
// waits for the registered stack read, and restart folds the start angles. For
// a forward, one shared CORDIC rotation unit runs CORDIC_STEPS iterations
// plus a result step for yaw, then for pitch, and one shared 34x34
// multiplier then forms the two direction products and three displacements,
// one product per cycle. The segment sits in an output register; the next
// command is taken as soon as the segment is registered, even if the sink has
// not yet taken it, but a following forward holds in its execute step until
// that register drains, which adds the sink's stall to its run time. The
// branch stack has no reset and no clearing pass; only entries below the
// stack level are ever loaded back into the turtle state.
// ----------------------------------------------------------------------------
module turtle_3d_path_interpreter #(
   parameter int unsigned STACK_DEPTH  = 64,
   parameter int unsigned CORDIC_STEPS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   t3d_req_if.sink                            req,
   t3d_rsp_if.source                          rsp,
   input  logic                               csr_write_enable,
   input  logic [t3d_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [t3d_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned ITER_W = $clog2(CORDIC_STEPS + 1);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EXEC   = 8'b0000_0010,
      ST_POP    = 8'b0000_0100,
      ST_CORDIC = 8'b0000_1000,
      ST_MUL    = 8'b0001_0000,
      ST_EMIT   = 8'b0010_0000,
      ST_INIT   = 8'b0100_0000,
      ST_FOLD   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [15:0] pitch;
      logic [15:0] yaw;
   } entry_type;

   // configuration registers
   logic [15:0] default_step_ff, default_yaw_ff, default_pitch_ff;
   logic [31:0] start_x_ff, start_y_ff, start_z_ff;
   logic [15:0] start_pitch_ff, start_yaw_ff;

   // turtle state
   logic [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [15:0] pitch_ff, yaw_ff;
   logic [LVL_W-1:0] level_ff;
   logic             overflow_ff;

   state_type   state_ff;
   logic [2:0]  op_ff;
   logic [15:0] amount_ff;

   // CORDIC unit
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [31:0] cz_ff;
   logic [ITER_W-1:0]  iter_ff;
   logic               neg_ff;
   logic               second_ff;   // pitch pass
   logic signed [33:0] cos_yaw_ff, sin_yaw_ff, cos_p_ff, sin_p_ff;

   // multiplier sequence
   logic [2:0]          mstep_ff;
   logic signed [33:0]  ma, mb;
   logic signed [67:0]  prod;
   logic signed [33:0]  dir_x_ff, dir_z_ff;

   // output register
   logic    rsp_valid_ff;
   t3d_pkg::rsp_type rsp_data_ff;

   // stack memory
   entry_type stack_mem [STACK_DEPTH];
   entry_type rd_ff;

   logic [15:0] step_dist;
   assign step_dist = (amount_ff != 16'd0) ? amount_ff : default_step_ff;

   // turn helper
   logic [15:0] turn_src, turn_dflt, turn_res;
   logic        turn_up;
   logic [16:0] turn_d;
   logic signed [18:0] turn_sum;
   always_comb begin
      turn_up   = (op_ff == t3d_pkg::OP_YAW_UP) || (op_ff == t3d_pkg::OP_PITCH_UP);
      turn_src  = ((op_ff == t3d_pkg::OP_YAW_UP) || (op_ff == t3d_pkg::OP_YAW_DN))
                  ? yaw_ff : pitch_ff;
      turn_dflt = ((op_ff == t3d_pkg::OP_YAW_UP) || (op_ff == t3d_pkg::OP_YAW_DN))
                  ? default_yaw_ff : default_pitch_ff;
      turn_d    = ({1'b0, ((amount_ff != 16'd0) ? amount_ff : turn_dflt)} + 17'd1) >> 1;
      turn_sum  = turn_up ? $signed({3'b000, turn_src}) + $signed({2'b00, turn_d})
                          : $signed({3'b000, turn_src}) - $signed({2'b00, turn_d});
      if (turn_sum >= $signed({2'b00, t3d_pkg::FULL_TURN}))
         turn_sum = turn_sum - $signed({2'b00, t3d_pkg::FULL_TURN});
      else if (turn_sum < 19'sd0)
         turn_sum = turn_sum + $signed({2'b00, t3d_pkg::FULL_TURN});
      turn_res  = turn_sum[15:0];
   end

   // CORDIC angle fold for the angle of the current pass
   logic [15:0]        cang;
   logic signed [17:0] ca;
   logic               cneg;
   always_comb begin
      cang = second_ff ? pitch_ff : yaw_ff;
      ca   = $signed({2'b00, cang});
      cneg = 1'b0;
      if (ca > $signed({1'b0, t3d_pkg::HALF_TURN}))
         ca = ca - $signed({1'b0, t3d_pkg::FULL_TURN});
      if (ca > $signed({1'b0, t3d_pkg::QUARTER_TURN})) begin
         ca = ca - $signed({1'b0, t3d_pkg::HALF_TURN});
         cneg = 1'b1;
      end else if (ca < -$signed({1'b0, t3d_pkg::QUARTER_TURN})) begin
         ca = ca + $signed({1'b0, t3d_pkg::HALF_TURN});
         cneg = 1'b1;
      end
   end

   // one CORDIC rotation
   logic signed [33:0] xs, ys;
   logic signed [31:0] atan_v;
   assign xs     = cx_ff >>> iter_ff;
   assign ys     = cy_ff >>> iter_ff;
   assign atan_v = $signed({2'b00, t3d_pkg::atan_deg23(5'(iter_ff))});

   // shared multiplier operand select
   always_comb begin
      unique case (mstep_ff)
         3'd0:    begin ma = cos_yaw_ff; mb = cos_p_ff; end
         3'd1:    begin ma = sin_yaw_ff; mb = cos_p_ff; end
         3'd2:    begin ma = $signed({18'd0, step_dist}); mb = dir_x_ff; end
         3'd3:    begin ma = $signed({18'd0, step_dist}); mb = sin_p_ff; end
         default: begin ma = $signed({18'd0, step_dist}); mb = dir_z_ff; end
      endcase
      prod = ma * mb;
   end

   logic signed [67:0] disp_full;
   logic [31:0]        disp;
   assign disp_full = (prod + 68'sd2097152) >>> 22;
   assign disp      = disp_full[31:0];

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         default_step_ff  <= 16'd256;
         default_yaw_ff   <= 16'd0;
         default_pitch_ff <= 16'd23040;
         start_x_ff       <= 32'd0;
         start_y_ff       <= 32'd0;
         start_z_ff       <= 32'd0;
         start_pitch_ff   <= 16'd0;
         start_yaw_ff     <= 16'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            {1'b0, t3d_pkg::REG_DEFAULT_STEP}:  default_step_ff  <= csr_write_data[15:0];
            {1'b0, t3d_pkg::REG_DEFAULT_YAW}:   default_yaw_ff   <= csr_write_data[15:0];
            {1'b0, t3d_pkg::REG_DEFAULT_PITCH}: default_pitch_ff <= csr_write_data[15:0];
            {1'b0, t3d_pkg::REG_START_X}:       start_x_ff       <= csr_write_data;
            {1'b0, t3d_pkg::REG_START_Y}:       start_y_ff       <= csr_write_data;
            {1'b0, t3d_pkg::REG_START_Z}:       start_z_ff       <= csr_write_data;
            {1'b0, t3d_pkg::REG_START_PITCH}:   start_pitch_ff   <= csr_write_data[15:0];
            {1'b0, t3d_pkg::REG_START_YAW}:     start_yaw_ff     <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // stack memory: write on push, registered read in every execute step, used by pop
   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC && op_ff == t3d_pkg::OP_PUSH
          && level_ff < LVL_W'(STACK_DEPTH))
         stack_mem[level_ff[ADDR_W-1:0]] <= '{pos_x_ff, pos_y_ff, pos_z_ff, pitch_ff, yaw_ff};
      if (state_ff == ST_EXEC)
         rd_ff <= stack_mem[ADDR_W'(level_ff - LVL_W'(1))];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_x_ff     <= 32'd0;
         pos_y_ff     <= 32'd0;
         pos_z_ff     <= 32'd0;
         pitch_ff     <= 16'd0;
         yaw_ff       <= 16'd0;
         level_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  op_ff     <= req.data.opcode;
                  amount_ff <= req.data.amount;
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               unique case (op_ff)
                  t3d_pkg::OP_FORWARD: begin
                     // hold until the previous segment has left the output register
                     second_ff <= 1'b0;
                     state_ff  <= (!rsp_valid_ff || rsp.ready) ? ST_INIT : ST_EXEC;
                  end
                  t3d_pkg::OP_YAW_UP, t3d_pkg::OP_YAW_DN: begin
                     yaw_ff   <= turn_res;
                     state_ff <= ST_IDLE;
                  end
                  t3d_pkg::OP_PITCH_UP, t3d_pkg::OP_PITCH_DN: begin
                     pitch_ff <= turn_res;
                     state_ff <= ST_IDLE;
                  end
                  t3d_pkg::OP_PUSH: begin
                     if (level_ff < LVL_W'(STACK_DEPTH)) level_ff <= level_ff + LVL_W'(1);
                     else                                overflow_ff <= 1'b1;
                     state_ff <= ST_IDLE;
                  end
                  t3d_pkg::OP_POP: begin
                     if (level_ff != '0) begin
                        level_ff <= level_ff - LVL_W'(1);
                        state_ff <= ST_POP;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end
                  default: begin
                     pos_x_ff <= start_x_ff;
                     pos_y_ff <= start_y_ff;
                     pos_z_ff <= start_z_ff;
                     pitch_ff <= start_pitch_ff;
                     yaw_ff   <= start_yaw_ff;
                     level_ff <= '0;
                     state_ff <= ST_FOLD;
                  end
               endcase
            end
            ST_FOLD: begin
               // reduce out-of-range start angles
               if ({1'b0, pitch_ff} >= t3d_pkg::FULL_TURN)
                  pitch_ff <= 16'(({1'b0, pitch_ff}) - t3d_pkg::FULL_TURN);
               if ({1'b0, yaw_ff} >= t3d_pkg::FULL_TURN)
                  yaw_ff <= 16'(({1'b0, yaw_ff}) - t3d_pkg::FULL_TURN);
               state_ff <= ST_IDLE;
            end
            ST_POP: begin
               pos_x_ff <= rd_ff.x;
               pos_y_ff <= rd_ff.y;
               pos_z_ff <= rd_ff.z;
               pitch_ff <= rd_ff.pitch;
               yaw_ff   <= rd_ff.yaw;
               state_ff <= ST_IDLE;
            end
            ST_INIT: begin
               // load CORDIC for the current angle
               cx_ff    <= t3d_pkg::GAIN_Q30;
               cy_ff    <= '0;
               cz_ff    <= 32'(ca) <<< 16;
               neg_ff   <= cneg;
               iter_ff  <= '0;
               state_ff <= ST_CORDIC;
            end
            ST_CORDIC: begin
               if (iter_ff == ITER_W'(CORDIC_STEPS)) begin
                  if (!second_ff) begin
                     cos_yaw_ff <= neg_ff ? -cx_ff : cx_ff;
                     sin_yaw_ff <= neg_ff ? -cy_ff : cy_ff;
                     second_ff  <= 1'b1;
                     state_ff   <= ST_INIT;
                  end else begin
                     cos_p_ff <= neg_ff ? -cx_ff : cx_ff;
                     sin_p_ff <= neg_ff ? -cy_ff : cy_ff;
                     mstep_ff <= 3'd0;
                     state_ff <= ST_MUL;
                  end
               end else begin
                  if (cz_ff >= 0) begin
                     cx_ff <= cx_ff - ys;
                     cy_ff <= cy_ff + xs;
                     cz_ff <= cz_ff - atan_v;
                  end else begin
                     cx_ff <= cx_ff + ys;
                     cy_ff <= cy_ff - xs;
                     cz_ff <= cz_ff + atan_v;
                  end
                  iter_ff <= iter_ff + ITER_W'(1);
               end
            end
            ST_MUL: begin
               mstep_ff <= mstep_ff + 3'd1;
               unique case (mstep_ff)
                  3'd0: dir_x_ff <= 34'(prod >>> 30);
                  3'd1: dir_z_ff <= 34'(prod >>> 30);
                  3'd2: begin
                     rsp_data_ff.from_x <= pos_x_ff;
                     pos_x_ff <= pos_x_ff + disp;
                  end
                  3'd3: begin
                     rsp_data_ff.from_y <= pos_y_ff;
                     pos_y_ff <= pos_y_ff + disp;
                  end
                  default: begin
                     rsp_data_ff.from_z <= pos_z_ff;
                     pos_z_ff <= pos_z_ff + disp;
                     state_ff <= ST_EMIT;
                  end
               endcase
            end
            ST_EMIT: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_data_ff.to_x          <= pos_x_ff;
                  rsp_data_ff.to_y          <= pos_y_ff;
                  rsp_data_ff.to_z          <= pos_z_ff;
                  rsp_data_ff.overflow_seen <= overflow_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
